/* rtl/rmq_pkg.sv */
// ----------------------------------------------------------------------------
// rmq_pkg
// Types and constants shared by the rotation-matrix-to-quaternion block.
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

    // Width of matrix entries and quaternion components.
    localparam int ELEM_W = 16;

    // Width of entry sums, differences and diagonal combinations.
    localparam int DW = 18;

    // Quotient bits produced by each divider lane.
    localparam int QW = 16;

    // Depth and pointer width of the queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;

    // Which quaternion component is the pivot (the one taken from the root).
    localparam logic [1:0] PIV_W = 2'd0;
    localparam logic [1:0] PIV_X = 2'd1;
    localparam logic [1:0] PIV_Y = 2'd2;
    localparam logic [1:0] PIV_Z = 2'd3;

    // Saturation limits.
    localparam logic [ELEM_W-1:0] SAT_POS = 16'h7FFF;
    localparam logic [ELEM_W-1:0] SAT_NEG = 16'h8000;

    // Input transaction: the nine matrix entries.
    typedef struct packed {
        logic signed [ELEM_W-1:0] m00;
        logic signed [ELEM_W-1:0] m01;
        logic signed [ELEM_W-1:0] m02;
        logic signed [ELEM_W-1:0] m10;
        logic signed [ELEM_W-1:0] m11;
        logic signed [ELEM_W-1:0] m12;
        logic signed [ELEM_W-1:0] m20;
        logic signed [ELEM_W-1:0] m21;
        logic signed [ELEM_W-1:0] m22;
    } t_mat_in;

    // Output transaction: the quaternion and the invalid flag.
    typedef struct packed {
        logic signed [ELEM_W-1:0] quat_w;
        logic signed [ELEM_W-1:0] quat_x;
        logic signed [ELEM_W-1:0] quat_y;
        logic signed [ELEM_W-1:0] quat_z;
        logic                     invalid;
    } t_quat_out;

    // Classified job: pivot, radicand without the added one, and the three
    // off-diagonal combinations in ascending component order skipping the pivot.
    typedef struct packed {
        logic [1:0]           pivot;
        logic signed [DW-1:0] base;
        logic signed [DW-1:0] d_a;
        logic signed [DW-1:0] d_b;
        logic signed [DW-1:0] d_c;
    } t_job;

endpackage

`default_nettype wire

/* rtl/rmq_front.sv */
// ----------------------------------------------------------------------------
// rmq_front
// Classifies a matrix: picks the pivot and forms the radicand base and the
// off-diagonal sums and differences, then registers the job.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_front
    import rmq_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  t_mat_in     i_data,
    output logic        o_job_valid,
    input  wire         i_job_ready,
    output t_job        o_job
);

    logic signed [DW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [DW-1:0] trace;
    t_job                 n_job;
    t_job                 r_job;
    logic                 r_valid;

    // Sign-extend the entries to the working width.
    assign e00 = DW'(i_data.m00);
    assign e01 = DW'(i_data.m01);
    assign e02 = DW'(i_data.m02);
    assign e10 = DW'(i_data.m10);
    assign e11 = DW'(i_data.m11);
    assign e12 = DW'(i_data.m12);
    assign e20 = DW'(i_data.m20);
    assign e21 = DW'(i_data.m21);
    assign e22 = DW'(i_data.m22);
    assign trace = e00 + e11 + e22;

    // Pivot selection; on ties the lower diagonal index stays the pivot.
    always_comb begin
        n_job = '0;
        if (trace > 0) begin
            n_job.pivot = PIV_W;
            n_job.base  = trace;
            n_job.d_a   = e21 - e12;
            n_job.d_b   = e02 - e20;
            n_job.d_c   = e10 - e01;
        end else if (e22 > e11 && e22 > e00) begin
            n_job.pivot = PIV_Z;
            n_job.base  = e22 - e00 - e11;
            n_job.d_a   = e10 - e01;
            n_job.d_b   = e02 + e20;
            n_job.d_c   = e12 + e21;
        end else if (e11 > e00) begin
            n_job.pivot = PIV_Y;
            n_job.base  = e11 - e22 - e00;
            n_job.d_a   = e02 - e20;
            n_job.d_b   = e01 + e10;
            n_job.d_c   = e21 + e12;
        end else begin
            n_job.pivot = PIV_X;
            n_job.base  = e00 - e11 - e22;
            n_job.d_a   = e21 - e12;
            n_job.d_b   = e10 + e01;
            n_job.d_c   = e20 + e02;
        end
    end

    // Output register of the front part.
    assign o_ready = !r_valid || i_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = r_valid;
    assign o_job       = r_job;

endmodule

`default_nettype wire

/* rtl/rmq_fifo.sv */
// ----------------------------------------------------------------------------
// rmq_fifo
// Short queue of classified jobs between the front and the back part.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_fifo
    import rmq_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_push_valid,
    output logic        o_push_ready,
    input  t_job        i_push_data,
    output logic        o_pop_valid,
    input  wire         i_pop_ready,
    output t_job        o_pop_data
);

    t_job              r_mem [0:QDEPTH-1];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != (QPTR_W+1)'(QDEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;
    assign o_pop_data = r_mem[r_rd_ptr];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/rmq_back.sv */
// ----------------------------------------------------------------------------
// rmq_back
// Pipelined square root, three pipelined dividers and the saturating output
// register. The whole pipeline advances together while the output can move.
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_back
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_job_valid,
    output logic        o_job_ready,
    input  t_job        i_job,
    output logic        o_valid,
    input  wire         i_ready,
    output t_quat_out   o_data
);

    // Radicand bits, root input bits (even), root bits, numerator and compare widths.
    localparam int RB = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 1;
    localparam int VW = ((RB + FRAC_BITS + 1) / 2) * 2;
    localparam int RT = VW / 2;
    localparam int NW = DW + FRAC_BITS + 1;
    localparam int CW = ((NW > RT + 17) ? NW : RT + 17) + 1;

    logic en;

    // Radicand stage signals.
    logic signed [RB:0] rad;

    // Square root pipeline: index 0 is the radicand register.
    logic           r_sq_vld  [0:RT];
    t_job           r_sq_job  [0:RT];
    logic           r_sq_bad  [0:RT];
    logic [VW-1:0]  r_sq_v    [0:RT];
    logic [RT+1:0]  r_sq_rem  [0:RT];
    logic [RT-1:0]  r_sq_root [0:RT];

    // Divider pipeline: index 0 is the numerator register.
    logic           r_dv_vld  [0:QW];
    logic [1:0]     r_dv_piv  [0:QW];
    logic           r_dv_bad  [0:QW];
    logic [RT-1:0]  r_dv_s    [0:QW];
    logic           r_dv_neg  [0:2][0:QW];
    logic           r_dv_ovf  [0:2][0:QW];
    logic [CW-1:0]  r_dv_rem  [0:2][0:QW];
    logic [QW-1:0]  r_dv_q    [0:2][0:QW];

    logic signed [DW-1:0] lane_d [0:2];

    t_quat_out  n_out;
    t_quat_out  r_out;
    logic       r_out_valid;

    // The pipeline moves whenever the output register is free or being taken.
    assign en          = !r_out_valid || i_ready;
    assign o_job_ready = en;

    // Radicand: add one and check that it is positive.
    assign rad = (RB+1)'(i_job.base) + ((RB+1)'(1) << FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld[0] <= 1'b0;
        end else if (en) begin
            r_sq_vld[0] <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_job[0]  <= i_job;
            r_sq_bad[0]  <= rad[RB] || (rad == '0);
            r_sq_v[0]    <= VW'(rad[RB-1:0]) << FRAC_BITS;
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
        end
    end

    // One root bit per stage.
    for (genvar t = 0; t < RT; t++) begin : g_sqrt
        logic [RT+1:0] rem_sh;
        logic [RT+1:0] trial;

        assign rem_sh = {r_sq_rem[t][RT-1:0], r_sq_v[t][VW-1 -: 2]};
        assign trial  = {r_sq_root[t], 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[t+1] <= 1'b0;
            end else if (en) begin
                r_sq_vld[t+1] <= r_sq_vld[t];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_job[t+1] <= r_sq_job[t];
                r_sq_bad[t+1] <= r_sq_bad[t];
                r_sq_v[t+1]   <= r_sq_v[t] << 2;
                if (rem_sh >= trial) begin
                    r_sq_rem[t+1]  <= rem_sh - trial;
                    r_sq_root[t+1] <= {r_sq_root[t][RT-2:0], 1'b1};
                end else begin
                    r_sq_rem[t+1]  <= rem_sh;
                    r_sq_root[t+1] <= {r_sq_root[t][RT-2:0], 1'b0};
                end
            end
        end
    end

    // Numerators: |d| scaled up, plus the root for rounding.
    assign lane_d[0] = r_sq_job[RT].d_a;
    assign lane_d[1] = r_sq_job[RT].d_b;
    assign lane_d[2] = r_sq_job[RT].d_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (en) begin
            r_dv_vld[0] <= r_sq_vld[RT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_piv[0] <= r_sq_job[RT].pivot;
            r_dv_bad[0] <= r_sq_bad[RT];
            r_dv_s[0]   <= r_sq_root[RT];
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [DW-1:0] mag;
        logic [CW-1:0] num;
        logic [CW-1:0] dvs;

        assign mag = lane_d[l][DW-1] ? DW'(-lane_d[l]) : DW'(lane_d[l]);
        assign num = CW'((NW'(mag) << FRAC_BITS) + NW'(r_sq_root[RT]));
        assign dvs = CW'({r_sq_root[RT], 1'b0});

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_neg[l][0] <= lane_d[l][DW-1];
                r_dv_ovf[l][0] <= num >= (dvs << QW);
                r_dv_rem[l][0] <= num;
                r_dv_q[l][0]   <= '0;
            end
        end

        // One quotient bit per stage, most significant first.
        for (genvar t = 0; t < QW; t++) begin : g_div
            logic [CW-1:0] trial;

            assign trial = CW'({r_dv_s[t], 1'b0}) << (QW - 1 - t);

            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_dv_neg[l][t+1] <= r_dv_neg[l][t];
                    r_dv_ovf[l][t+1] <= r_dv_ovf[l][t];
                    if (r_dv_rem[l][t] >= trial) begin
                        r_dv_rem[l][t+1] <= r_dv_rem[l][t] - trial;
                        r_dv_q[l][t+1]   <= {r_dv_q[l][t][QW-2:0], 1'b1};
                    end else begin
                        r_dv_rem[l][t+1] <= r_dv_rem[l][t];
                        r_dv_q[l][t+1]   <= {r_dv_q[l][t][QW-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // Shared control of the divider stages.
    for (genvar t = 0; t < QW; t++) begin : g_dctl
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[t+1] <= 1'b0;
            end else if (en) begin
                r_dv_vld[t+1] <= r_dv_vld[t];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_piv[t+1] <= r_dv_piv[t];
                r_dv_bad[t+1] <= r_dv_bad[t];
                r_dv_s[t+1]   <= r_dv_s[t];
            end
        end
    end

    // Saturate each lane and the pivot, place them by pivot, zero if invalid.
    always_comb begin
        logic [ELEM_W-1:0] lv [0:2];
        logic [RT:0]       pr;
        logic [ELEM_W-1:0] pv;

        for (int l = 0; l < 3; l++) begin
            if (r_dv_neg[l][QW]) begin
                if (r_dv_ovf[l][QW] || r_dv_q[l][QW] > QW'(32768)) begin
                    lv[l] = SAT_NEG;
                end else begin
                    lv[l] = ELEM_W'(QW'(0) - r_dv_q[l][QW]);
                end
            end else begin
                if (r_dv_ovf[l][QW] || r_dv_q[l][QW] > QW'(32767)) begin
                    lv[l] = SAT_POS;
                end else begin
                    lv[l] = ELEM_W'(r_dv_q[l][QW]);
                end
            end
        end

        pr = ((RT+1)'(r_dv_s[QW]) + 1'b1) >> 1;
        pv = (pr > (RT+1)'(32767)) ? SAT_POS : ELEM_W'(pr);

        n_out = '0;
        unique case (r_dv_piv[QW])
            PIV_W: begin
                n_out.quat_w = pv;
                n_out.quat_x = lv[0];
                n_out.quat_y = lv[1];
                n_out.quat_z = lv[2];
            end
            PIV_X: begin
                n_out.quat_w = lv[0];
                n_out.quat_x = pv;
                n_out.quat_y = lv[1];
                n_out.quat_z = lv[2];
            end
            PIV_Y: begin
                n_out.quat_w = lv[0];
                n_out.quat_x = lv[1];
                n_out.quat_y = pv;
                n_out.quat_z = lv[2];
            end
            default: begin
                n_out.quat_w = lv[0];
                n_out.quat_x = lv[1];
                n_out.quat_y = lv[2];
                n_out.quat_z = pv;
            end
        endcase

        if (r_dv_bad[QW]) begin
            n_out = '0;
            n_out.invalid = 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_dv_vld[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

`ifndef SYNTHESIS
    // An invalid result carries an all-zero quaternion.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.invalid |->
            o_data.quat_w == '0 && o_data.quat_x == '0 &&
            o_data.quat_y == '0 && o_data.quat_z == '0)
        else $error("invalid result with nonzero quaternion");

    // A stalled output blocks the whole pipeline.
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_job_ready)
        else $error("pipeline advanced while output stalled");

    // Nothing leaves the pipeline right after reset.
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid && !r_dv_vld[QW])
        else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire

/* rtl/rotation_matrix_to_quaternion_unit.sv */
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Converts a 3x3 rotation matrix to a unit quaternion by Shepperd's method.
// ----------------------------------------------------------------------------
// The unit accepts one matrix per clock cycle while the output is not stalled
// and returns one quaternion per matrix, in order. A matrix passes the front
// register, the job queue, the radicand register, the bit-per-stage square
// root (RT stages, RT = ceil((max(FRAC_BITS,17)+1+FRAC_BITS)/2), 16 at the
// default), the numerator register, sixteen divider stages and the output
// register. A stalled output holds the back pipeline; the queue lets the
// front keep accepting until it fills.
`default_nettype none

module rotation_matrix_to_quaternion_unit
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  t_mat_in     i_data,
    output logic        o_valid,
    input  wire         i_ready,
    output t_quat_out   o_data
);

    logic f_valid, f_ready, b_valid, b_ready;
    t_job f_job, b_job;

    // Front: classification.
    rmq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_job_valid (f_valid),
        .i_job_ready (f_ready),
        .o_job       (f_job)
    );

    // Queue between front and back.
    rmq_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_valid),
        .o_push_ready (f_ready),
        .i_push_data  (f_job),
        .o_pop_valid  (b_valid),
        .i_pop_ready  (b_ready),
        .o_pop_data   (b_job)
    );

    // Back: root, division and saturation.
    rmq_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (b_valid),
        .o_job_ready (b_ready),
        .i_job       (b_job),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

`default_nettype wire
